FILE: rtl/rau_pkg.sv
// Package: shared types, constants and command codes for the rational arithmetic unit.
package rau_pkg;

   localparam int WIDTH_DEFAULT = 32;

   typedef enum logic [2:0] {
      CMD_ADD = 3'd0,
      CMD_SUB = 3'd1,
      CMD_MUL = 3'd2,
      CMD_DIV = 3'd3,
      CMD_EQU = 3'd4
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ZERO_DEN = 2'd1,
      STATUS_DIV_ZERO = 2'd2,
      STATUS_OVERFLOW = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0]         command;
      logic signed [31:0] a_numerator;
      logic signed [31:0] a_denominator;
      logic signed [31:0] b_numerator;
      logic signed [31:0] b_denominator;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_numerator;
      logic [30:0]        result_denominator;
      logic               operands_equal;
      logic [1:0]         status;
   } rsp_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A,
      ST_RED_B,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_COMBINE,
      ST_RED_R,
      ST_DONE
   } state_type;

   // Request to the reduction unit
   typedef struct packed {
      logic start;
   } red_ctl_type;

   // Status from the reduction unit
   typedef struct packed {
      logic busy;
      logic done;
   } red_sts_type;

endpackage

FILE: rtl/rau_reduce.sv
// Reduction unit: divides a magnitude pair by its gcd with one shared subtractor per cycle.
module rau_reduce #(
   parameter int MAG_W = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  rau_pkg::red_ctl_type ctl,
   input  logic [MAG_W-1:0]     num_mag,
   input  logic [MAG_W-1:0]     den_mag,
   output rau_pkg::red_sts_type sts,
   output logic [MAG_W-1:0]     num_out,
   output logic [MAG_W-1:0]     den_out
);

   localparam int CNT_W = $clog2(MAG_W + 1);

   typedef enum logic [2:0] {
      R_IDLE, R_GCD, R_DIVN, R_DIVD, R_DONE
   } rphase_type;

   rphase_type       phase_ff, phase_in;
   logic [MAG_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [MAG_W-1:0] g_ff, g_in;
   logic [MAG_W-1:0] q_ff, q_in, rem_ff, rem_in;
   logic [MAG_W-1:0] nq_ff, nq_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] k_ff, k_in;
   logic [MAG_W:0]   trial;
   logic [MAG_W-1:0] sub_a, sub_b;
   logic [MAG_W:0]   diff;

   // Shared subtractor
   assign diff = {1'b0, sub_a} - {1'b0, sub_b};

   always_comb begin
      trial = {rem_ff, q_ff[MAG_W-1]};
      if (phase_ff == R_GCD) begin
         sub_a = (x_ff >= y_ff) ? x_ff : y_ff;
         sub_b = (x_ff >= y_ff) ? y_ff : x_ff;
      end else begin
         sub_a = trial[MAG_W-1:0];
         sub_b = g_ff;
      end
   end

   // Advance gcd (binary, shared factors of two counted), then two restoring divides
   always_comb begin
      phase_in = phase_ff;
      x_in = x_ff; y_in = y_ff; g_in = g_ff;
      q_in = q_ff; rem_in = rem_ff; nq_in = nq_ff; cnt_in = cnt_ff;
      k_in = k_ff;
      unique case (phase_ff)
         R_IDLE: begin
            if (ctl.start) begin
               x_in = num_mag;
               y_in = den_mag;
               k_in = '0;
               phase_in = R_GCD;
            end
         end
         R_GCD: begin
            if (x_ff == '0 || y_ff == '0) begin
               g_in = ((x_ff == '0) ? y_ff : x_ff) << k_ff;
               q_in = num_mag;
               rem_in = '0;
               cnt_in = CNT_W'(MAG_W);
               phase_in = R_DIVN;
            end else if (x_ff[0] == 1'b0 && y_ff[0] == 1'b0) begin
               // halve both and count the shared factor of two
               x_in = x_ff >> 1;
               y_in = y_ff >> 1;
               k_in = k_ff + 1'b1;
            end else if (x_ff[0] == 1'b0) begin
               x_in = x_ff >> 1;
            end else if (y_ff[0] == 1'b0) begin
               y_in = y_ff >> 1;
            end else if (x_ff >= y_ff) begin
               x_in = diff[MAG_W-1:0];
            end else begin
               y_in = diff[MAG_W-1:0];
            end
         end
         R_DIVN, R_DIVD: begin
            if (trial >= {1'b0, g_ff}) begin
               rem_in = diff[MAG_W-1:0];
               q_in = {q_ff[MAG_W-2:0], 1'b1};
            end else begin
               rem_in = trial[MAG_W-1:0];
               q_in = {q_ff[MAG_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               if (phase_ff == R_DIVN) begin
                  nq_in = q_in;
                  q_in = den_mag;
                  rem_in = '0;
                  cnt_in = CNT_W'(MAG_W);
                  phase_in = R_DIVD;
               end else begin
                  phase_in = R_DONE;
               end
            end
         end
         R_DONE: phase_in = R_IDLE;
         default: phase_in = R_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= R_IDLE;
      else phase_ff <= phase_in;
      x_ff <= x_in; y_ff <= y_in; g_ff <= g_in;
      q_ff <= q_in; rem_ff <= rem_in; nq_ff <= nq_in; cnt_ff <= cnt_in;
      k_ff <= k_in;
   end

   assign sts.busy = (phase_ff != R_IDLE);
   assign sts.done = (phase_ff == R_DONE);
   assign num_out  = nq_ff;
   assign den_out  = q_ff;

   // Division counter stays in range while dividing
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == R_DIVN || phase_ff == R_DIVD) |-> (cnt_ff != '0))
      else $error("reduce: divide counter underflow");
   // Done lasts one cycle
   assert property (@(posedge clock) disable iff (reset)
      sts.done |=> !sts.done)
      else $error("reduce: done held");
   // Gcd is nonzero once division starts
   assert property (@(posedge clock) disable iff (reset)
      (phase_ff == R_DIVN) |-> (g_ff != '0))
      else $error("reduce: zero gcd");

endmodule

FILE: rtl/rational_arithmetic_unit.sv
// Top level: sequencer, shared multiplier and output register of the rational arithmetic unit.
//
//   channel | direction | ports
//   req     | in        | req_valid, req_stall, req_data
//   rsp     | out       | rsp_valid, rsp_stall, rsp_data
//
// A zero denominator goes straight to the done state; an equality test, or a divide by a
// zero operand b, ends once both operands are reduced. Each reduction pass spends one binary
// gcd step per cycle (up to about two per bit) and two 64-step restoring divides.
// The reduction unit runs up to three times: operand a, operand b, result.
// Reset clears the sequencer and the result valid flag.
// req_stall is high from acceptance until the result transaction leaves.
module rational_arithmetic_unit #(
   parameter int WIDTH = rau_pkg::WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rau_pkg::rsp_type rsp_data
);

   localparam int MW = 2 * WIDTH;

   rau_pkg::state_type state_ff, state_in;
   logic [2:0]       cmd_ff;
   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;   // magnitudes
   logic             ans_ff, bns_ff, ads_ff, bds_ff;
   logic [WIDTH-1:0] an_in, ad_in, bn_in, bd_in;
   logic             ans_in, bns_in;
   logic [MW-1:0]    p_ff [3];
   logic             rneg_ff, rneg_in;
   logic [MW-1:0]    rn_ff, rn_in;
   logic             mul_ready;
   logic [WIDTH-1:0] mul_a, mul_b;
   logic [MW-1:0]    mul_p;
   logic [MW-1:0]    red_n, red_d, red_no, red_do;
   rau_pkg::red_ctl_type red_ctl;
   rau_pkg::red_sts_type red_sts;
   logic             rsp_valid_ff;
   rau_pkg::rsp_type rsp_ff, rsp_in;
   logic             load_rsp;
   logic             req_take;
   logic             x_neg, y_neg, t_neg;
   logic [MW-1:0]    half;

   function automatic logic [WIDTH-1:0] mag_of(input logic [31:0] raw);
      logic [WIDTH-1:0] v;
      v = raw[WIDTH-1:0];
      return v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   assign half = MW'(1) << (WIDTH - 1);

   // Accept a request transaction
   assign req_take = req_valid && !req_stall;

   // Shared multiplier, operands by state
   always_comb begin
      unique case (state_ff)
         rau_pkg::ST_MUL1: begin
            mul_a = an_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_MUL) ? bn_ff : bd_ff;
         end
         rau_pkg::ST_MUL2: begin
            mul_a = (cmd_ff == rau_pkg::CMD_DIV) ? ad_ff : bn_ff;
            mul_b = (cmd_ff == rau_pkg::CMD_DIV) ? bn_ff : ad_ff;
         end
         default: begin
            mul_a = ad_ff;
            mul_b = bd_ff;
         end
      endcase
   end
   assign mul_p = MW'(mul_a) * MW'(mul_b);

   // Reduction unit operands
   always_comb begin
      unique case (state_ff)
         rau_pkg::ST_RED_A: begin red_n = MW'(an_ff); red_d = MW'(ad_ff); end
         rau_pkg::ST_RED_B: begin red_n = MW'(bn_ff); red_d = MW'(bd_ff); end
         default:           begin red_n = rn_ff;      red_d = p_ff[2]; end
      endcase
   end

   rau_reduce #(.MAG_W(MW)) u_reduce (
      .clock   (clock),
      .reset   (reset),
      .ctl     (red_ctl),
      .num_mag (red_n),
      .den_mag (red_d),
      .sts     (red_sts),
      .num_out (red_no),
      .den_out (red_do)
   );

   assign mul_ready = 1'b1;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (req_take) begin
               if (mag_of(req_data.a_denominator) == '0 ||
                   mag_of(req_data.b_denominator) == '0)
                  state_in = rau_pkg::ST_DONE;
               else
                  state_in = rau_pkg::ST_RED_A;
            end
         end
         rau_pkg::ST_RED_A: if (red_sts.done) state_in = rau_pkg::ST_RED_B;
         rau_pkg::ST_RED_B: begin
            if (red_sts.done) begin
               if (cmd_ff >= rau_pkg::CMD_EQU ||
                   (cmd_ff == rau_pkg::CMD_DIV && red_no == '0))
                  state_in = rau_pkg::ST_DONE;
               else
                  state_in = rau_pkg::ST_MUL1;
            end
         end
         rau_pkg::ST_MUL1:    state_in = rau_pkg::ST_MUL2;
         rau_pkg::ST_MUL2:    state_in = rau_pkg::ST_MUL3;
         rau_pkg::ST_MUL3:    state_in = rau_pkg::ST_COMBINE;
         rau_pkg::ST_COMBINE: state_in = rau_pkg::ST_RED_R;
         rau_pkg::ST_RED_R:   if (red_sts.done) state_in = rau_pkg::ST_DONE;
         rau_pkg::ST_DONE:    if (!rsp_valid_ff || !rsp_stall) state_in = rau_pkg::ST_IDLE;
         default:             state_in = rau_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      red_ctl.start = 1'b0;
      unique case (state_ff)
         rau_pkg::ST_RED_A, rau_pkg::ST_RED_B, rau_pkg::ST_RED_R:
            red_ctl.start = !red_sts.busy && mul_ready;
         default: red_ctl.start = 1'b0;
      endcase
   end

   // Operand capture and reduced operand updates
   always_comb begin
      an_in = an_ff; ad_in = ad_ff; bn_in = bn_ff; bd_in = bd_ff;
      ans_in = ans_ff; bns_in = bns_ff;
      if (req_take) begin
         an_in = mag_of(req_data.a_numerator);
         ad_in = mag_of(req_data.a_denominator);
         bn_in = mag_of(req_data.b_numerator);
         bd_in = mag_of(req_data.b_denominator);
         ans_in = req_data.a_numerator[WIDTH-1];
         bns_in = req_data.b_numerator[WIDTH-1];
      end else if (state_ff == rau_pkg::ST_RED_A && red_sts.done) begin
         an_in = red_no[WIDTH-1:0];
         ad_in = (an_ff == '0) ? WIDTH'(1) : red_do[WIDTH-1:0];
         ans_in = (an_ff != '0) && (ans_ff != ads_ff);
      end else if (state_ff == rau_pkg::ST_RED_B && red_sts.done) begin
         bn_in = red_no[WIDTH-1:0];
         bd_in = (bn_ff == '0) ? WIDTH'(1) : red_do[WIDTH-1:0];
         bns_in = (bn_ff != '0) && (bns_ff != bds_ff);
      end
   end

   // Sign of the cross terms and the combined result numerator
   always_comb begin
      t_neg = bns_ff ^ (cmd_ff == rau_pkg::CMD_SUB && bn_ff != '0);
      x_neg = ans_ff;
      y_neg = t_neg;
      rn_in = rn_ff;
      rneg_in = rneg_ff;
      if (state_ff == rau_pkg::ST_COMBINE) begin
         if (cmd_ff == rau_pkg::CMD_MUL || cmd_ff == rau_pkg::CMD_DIV) begin
            rn_in = p_ff[0];
            rneg_in = (ans_ff != bns_ff) && p_ff[0] != '0;
         end else if (x_neg == y_neg) begin
            rn_in = p_ff[0] + p_ff[1];
            rneg_in = x_neg;
         end else if (p_ff[0] >= p_ff[1]) begin
            rn_in = p_ff[0] - p_ff[1];
            rneg_in = x_neg;
         end else begin
            rn_in = p_ff[1] - p_ff[0];
            rneg_in = y_neg;
         end
      end
   end

   // Build the result transaction
   always_comb begin
      rsp_in = '0;
      if (state_ff == rau_pkg::ST_IDLE) begin
         rsp_in.status = rau_pkg::STATUS_ZERO_DEN;
      end else if (state_ff == rau_pkg::ST_RED_B) begin
         if (cmd_ff >= rau_pkg::CMD_EQU)
            rsp_in.operands_equal = (ans_ff == bns_in) && (an_ff == bn_in) &&
                                    (ad_ff == bd_in);
         else
            rsp_in.status = rau_pkg::STATUS_DIV_ZERO;
      end else begin
         if (rn_ff == '0) begin
            rsp_in.result_denominator = 31'd1;
         end else if ((rneg_ff ? red_no > half : red_no > half - 1'b1) ||
                      red_do > half - 1'b1) begin
            rsp_in.status = rau_pkg::STATUS_OVERFLOW;
         end else begin
            rsp_in.result_numerator =
               32'(signed'(rneg_ff ? (~red_no[WIDTH-1:0] + 1'b1) : red_no[WIDTH-1:0]));
            rsp_in.result_denominator = 31'(red_do);
         end
      end
   end

   assign load_rsp = state_in == rau_pkg::ST_DONE && state_ff != rau_pkg::ST_DONE;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == rau_pkg::ST_DONE && state_in == rau_pkg::ST_IDLE)
            rsp_valid_ff <= 1'b1;
         else if (!rsp_stall)
            rsp_valid_ff <= 1'b0;
      end
      an_ff <= an_in; ad_ff <= ad_in; bn_ff <= bn_in; bd_ff <= bd_in;
      ans_ff <= ans_in; bns_ff <= bns_in;
      rn_ff <= rn_in; rneg_ff <= rneg_in;
      if (req_take) begin
         cmd_ff <= req_data.command;
         ads_ff <= req_data.a_denominator[WIDTH-1];
         bds_ff <= req_data.b_denominator[WIDTH-1];
      end
      // Hold multiplier products
      if (state_ff == rau_pkg::ST_MUL1) p_ff[0] <= mul_p;
      if (state_ff == rau_pkg::ST_MUL2) p_ff[1] <= mul_p;
      if (state_ff == rau_pkg::ST_MUL3) p_ff[2] <= mul_p;
      if (state_ff == rau_pkg::ST_COMBINE &&
          (cmd_ff == rau_pkg::CMD_MUL || cmd_ff == rau_pkg::CMD_DIV)) begin
         if (cmd_ff == rau_pkg::CMD_DIV) p_ff[2] <= p_ff[1];
      end
      if (load_rsp) rsp_ff <= rsp_in;
   end

   // Output register drains when the result is taken; hold requests while it waits
   assign req_stall = (state_ff != rau_pkg::ST_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff && state_ff != rau_pkg::ST_DONE;
   assign rsp_data  = rsp_ff;

   // Result leaves only from a loaded register
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == rau_pkg::ST_DONE))
      else $error("top: result without sequencer done");
   // Reduction starts only in reduce states
   assert property (@(posedge clock) disable iff (reset)
      red_ctl.start |-> (state_ff == rau_pkg::ST_RED_A || state_ff == rau_pkg::ST_RED_B ||
                         state_ff == rau_pkg::ST_RED_R))
      else $error("top: stray reduce start");
   // Errors carry a zero result
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != rau_pkg::STATUS_OK) |->
      (rsp_data.result_denominator == '0))
      else $error("top: error result not cleared");

endmodule
